[design/sqch_pkg.sv]
package sqch_pkg;

	// Command codes carried on the input word
	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_SAMPLE = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_DUTY0 = 3'd0;
	localparam logic [2:0] CFG_DUTY1 = 3'd1;
	localparam logic [2:0] CFG_DUTY2 = 3'd2;
	localparam logic [2:0] CFG_DUTY3 = 3'd3;
	localparam logic [2:0] CFG_RATE  = 3'd4;

	// Decoded bus addresses
	localparam logic [15:0] ADDR_LEN  = 16'hFF16;
	localparam logic [15:0] ADDR_ENV  = 16'hFF17;
	localparam logic [15:0] ADDR_FLO  = 16'hFF18;
	localparam logic [15:0] ADDR_FHI  = 16'hFF19;

	localparam logic [7:0] LEN_MASK = 8'h3F;
	localparam logic [7:0] CTL_MASK = 8'hBF;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_TONE,
		ST_MUL,
		ST_DIV_THR,
		ST_STEP,
		ST_OUT
	} state_t;

endpackage

[design/sqch_div.sv]
// Restoring divider, one quotient bit per cycle
module sqch_div #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          dividend,
	input  logic [W-1:0]          divisor,
	output logic                  busy,
	output logic [W-1:0]          quotient
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	// Shift one bit of dividend into the partial remainder each cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;
endmodule

[design/square_wave_sound_channel_top.sv]
// Square-wave sound channel. Each input word is a register read, a register
// write, a tick of CPU time or a sample request, and each of them gives its own
// output word. Reads, writes and ticks pass straight to the output state.
// A sample request first works out the step threshold, which needs two
// 32-bit divisions (tone rate, then sample rate over pattern rate) on one
// shared bit-serial divider, one quotient bit per cycle. tready is low while
// a word is in work or waiting in the output register.
module square_wave_sound_channel_top #(
	parameter int CPU_CLOCK_HZ  = 4194304,
	parameter int PATTERN_STEPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[1:0], address[17:2], write_data[25:18], tick_cycles[35:26], pad
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0], sample_level[11:8], channel_on[12], pad
	output logic [15:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import sqch_pkg::*;

	localparam int          SW       = $clog2(PATTERN_STEPS);
	localparam logic [21:0] LEN_UNIT = 22'(CPU_CLOCK_HZ / 256);
	localparam logic [21:0] ENV_UNIT = 22'(CPU_CLOCK_HZ / 64);
	localparam logic [21:0] LEN_FULL = 22'(64 * (CPU_CLOCK_HZ / 256));

	state_t state_q, state_d;

	logic [31:0] duty_q [4];
	logic [17:0] rate_q;
	logic [7:0]  len_copy_q, env_copy_q, ctl_copy_q;
	logic [1:0]  duty_sel_q;
	logic [10:0] freq_q;
	logic        len_en_q, env_up_q, sound_q;
	logic [21:0] len_rem_q, env_rem_q;
	logic [3:0]  vol_q;
	logic [SW-1:0] step_q;
	logic [23:0] step_cnt_q;

	// input item hold
	cmd_t        cmd_q;
	logic [15:0] addr_q;
	logic [7:0]  wdata_q;
	logic [9:0]  cyc_q;

	logic [31:0] tone_q;
	logic [7:0]  rd_q;
	logic [3:0]  lvl_q;

	logic        div_start, div_busy;
	logic [31:0] div_a, div_b, div_q;

	sqch_div #(.W(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .busy(div_busy), .quotient(div_q)
	);

	assign s_tready  = (state_q == ST_IDLE) && !m_tvalid;
	assign cfg_ready = 1'b1;
	assign m_tdata   = {3'b000, sound_q, lvl_q, rd_q};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_tvalid && s_tready)
				state_d = (cmd_t'(s_tdata[1:0]) == CMD_SAMPLE) ? ST_DIV_TONE : ST_OUT;
			ST_DIV_TONE: if (!div_busy && !div_start) state_d = ST_MUL;
			ST_MUL:      state_d = ST_DIV_THR;
			ST_DIV_THR:  if (!div_busy && !div_start) state_d = ST_STEP;
			ST_STEP:     state_d = ST_OUT;
			ST_OUT:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	logic started_q;

	// Divider operands and start pulse
	always_comb begin
		div_start = 1'b0;
		div_a = 32'd131072;
		div_b = 32'd2048 - {21'd0, freq_q};
		unique case (state_q)
			ST_DIV_TONE: div_start = !started_q;
			ST_DIV_THR: begin
				div_start = !started_q;
				div_a = {6'd0, rate_q, 8'd0};
				div_b = tone_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			started_q <= (state_d == state_q) && (state_q == ST_DIV_TONE ||
				state_q == ST_DIV_THR);
		end
	end

	// Capture the input word, and the scaled tone rate in ST_MUL
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= cmd_t'(s_tdata[1:0]);
			addr_q  <= s_tdata[17:2];
			wdata_q <= s_tdata[25:18];
			cyc_q   <= s_tdata[35:26];
		end
		if (state_q == ST_MUL)
			tone_q <= div_q * 32'(PATTERN_STEPS);
	end

	logic [21:0] cyc_ext;
	logic [24:0] cnt_sub;
	logic [SW-1:0] step_nx;
	logic [3:0]  level;
	logic [7:0]  prod;
	logic [15:0] lvl_mul;
	logic        len_expire;
	logic [7:0]  rd_nx;

	assign cyc_ext = {12'd0, cyc_q};
	assign cnt_sub = {1'b0, step_cnt_q} - div_q[24:0] + 25'd256;
	assign step_nx = (32'(step_q) + 32'd1 >= 32'(PATTERN_STEPS)) ? '0 : step_q + 1'b1;
	assign level   = duty_q[duty_sel_q][4 * 32'(step_q) +: 4];
	assign prod    = vol_q * level;
	// Divide by 15 through a reciprocal multiply, exact for products up to 225
	assign lvl_mul = {8'd0, prod} * 16'd137;
	assign len_expire = len_en_q && (cyc_ext >= len_rem_q);

	// Register read-back with fixed masks
	always_comb begin
		priority case (addr_q)
			ADDR_LEN: rd_nx = len_copy_q;
			ADDR_ENV: rd_nx = env_copy_q;
			ADDR_FHI: rd_nx = ctl_copy_q;
			default:  rd_nx = 8'hFF;
		endcase
	end

	// Architectural state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q[0] <= 32'hF000_0000;
			duty_q[1] <= 32'hFF00_0000;
			duty_q[2] <= 32'hFFFF_0000;
			duty_q[3] <= 32'h00FF_FFFF;
			rate_q <= 18'd44100;
			len_copy_q <= '0; env_copy_q <= '0; ctl_copy_q <= '0;
			duty_sel_q <= '0; freq_q <= '0; len_en_q <= 1'b0;
			len_rem_q <= '0; vol_q <= '0; env_up_q <= 1'b0;
			env_rem_q <= '0; sound_q <= 1'b0; step_q <= '0;
			step_cnt_q <= '0; m_tvalid <= 1'b0; rd_q <= '0; lvl_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_DUTY0: duty_q[0] <= cfg_data;
					CFG_DUTY1: duty_q[1] <= cfg_data;
					CFG_DUTY2: duty_q[2] <= cfg_data;
					CFG_DUTY3: duty_q[3] <= cfg_data;
					CFG_RATE:  rate_q <= cfg_data[17:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			// Advance duty step against the threshold
			if (state_q == ST_STEP) begin
				if ({8'd0, step_cnt_q} <= div_q) begin
					step_cnt_q <= step_cnt_q + 24'd256;
				end else begin
					step_q     <= step_nx;
					step_cnt_q <= cnt_sub[23:0];
				end
			end
			if (state_q == ST_OUT) begin
				m_tvalid <= 1'b1;
				rd_q  <= (cmd_q == CMD_READ) ? rd_nx : 8'd0;
				lvl_q <= (cmd_q == CMD_SAMPLE) ? lvl_mul[14:11] : 4'd0;
				unique case (cmd_q)
					CMD_READ: ;
					CMD_WRITE: begin
						priority case (addr_q)
							ADDR_LEN: begin
								duty_sel_q <= wdata_q[7:6];
								len_rem_q  <= 22'(({16'd0, 6'd0} + 22'd64 -
									{16'd0, wdata_q[5:0]}) * LEN_UNIT);
								len_copy_q <= wdata_q | LEN_MASK;
							end
							ADDR_ENV: begin
								vol_q      <= wdata_q[7:4];
								env_up_q   <= wdata_q[3];
								env_rem_q  <= 22'({19'd0, wdata_q[2:0]} * ENV_UNIT);
								env_copy_q <= wdata_q;
							end
							ADDR_FLO: freq_q[7:0] <= wdata_q;
							ADDR_FHI: begin
								freq_q[10:8] <= wdata_q[2:0];
								len_en_q     <= wdata_q[6];
								if (wdata_q[7]) begin
									sound_q <= (env_copy_q[7:4] != 4'd0);
									if (len_rem_q == '0) len_rem_q <= LEN_FULL;
									vol_q <= env_copy_q[7:4];
								end
								ctl_copy_q <= wdata_q | CTL_MASK;
							end
							default: ;
						endcase
					end
					CMD_TICK: begin
						if (len_en_q) begin
							if (cyc_ext >= len_rem_q) len_rem_q <= '0;
							else len_rem_q <= len_rem_q - cyc_ext;
						end
						if (len_expire)
							sound_q <= 1'b0;
						// Envelope runs only if the channel still sounds after the length count
						if (env_rem_q != '0 && sound_q && !len_expire) begin
							if (cyc_ext >= env_rem_q) begin
								if (env_up_q && vol_q != 4'd15) vol_q <= vol_q + 1'b1;
								if (!env_up_q && vol_q != 4'd0) vol_q <= vol_q - 1'b1;
								env_rem_q <= 22'({19'd0, env_copy_q[2:0]} * ENV_UNIT);
							end else begin
								env_rem_q <= env_rem_q - cyc_ext;
							end
						end
					end
					CMD_SAMPLE: ;
					default: ;
				endcase
			end
		end
	end
endmodule

[sim/square_wave_sound_channel_checker.sv]
`timescale 1ns / 1ps

// Watch the channel ports, predict every output word and compare in order.
module square_wave_sound_channel_checker #(
	parameter int CPU_CLOCK_HZ  = 4194304,
	parameter int PATTERN_STEPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending_words
);
	import sqch_pkg::*;

	typedef struct packed {
		logic [7:0] rd;
		logic [3:0] lvl;
		logic       on;
	} chan_word_t;

	// Mirror of the channel state
	logic [31:0] duty_tbl [4];
	logic [17:0] sample_rate;
	logic [7:0]  len_copy, env_copy, ctl_copy;
	logic [1:0]  duty_sel;
	logic [10:0] freq;
	logic        len_en, env_up, sounding;
	logic [31:0] len_left, env_left;
	logic [3:0]  vol;
	logic [2:0]  step_idx;
	logic [23:0] step_cnt;

	chan_word_t expected_words [$];

	function automatic logic [31:0] full_length();
		return 64 * (CPU_CLOCK_HZ / 256);
	endfunction

	task automatic apply_write(input logic [15:0] addr, input logic [7:0] v);
		case (addr)
			ADDR_LEN: begin
				duty_sel = v[7:6];
				len_left = (64 - v[5:0]) * (CPU_CLOCK_HZ / 256);
				len_copy = v | LEN_MASK;
			end
			ADDR_ENV: begin
				vol = v[7:4];
				env_up = v[3];
				env_left = v[2:0] * (CPU_CLOCK_HZ / 64);
				env_copy = v;
			end
			ADDR_FLO: freq = {freq[10:8], v};
			ADDR_FHI: begin
				freq = {v[2:0], freq[7:0]};
				len_en = v[6];
				if (v[7]) begin
					sounding = 1'b1;
					if (len_left == 0)
						len_left = full_length();
					vol = env_copy[7:4];
					if (vol == 0)
						sounding = 1'b0;
				end
				ctl_copy = v | CTL_MASK;
			end
			default: ;
		endcase
	endtask

	function automatic logic [7:0] read_back(input logic [15:0] addr);
		case (addr)
			ADDR_LEN: return len_copy;
			ADDR_ENV: return env_copy;
			ADDR_FHI: return ctl_copy;
			default:  return 8'hFF;
		endcase
	endfunction

	task automatic apply_tick(input logic [9:0] cyc);
		if (len_en) begin
			if (cyc >= len_left) begin
				sounding = 1'b0;
				len_left = 0;
			end else begin
				len_left -= cyc;
			end
		end
		if (env_left != 0 && sounding) begin
			if (cyc >= env_left) begin
				if (env_up && vol < 15)
					vol++;
				else if (!env_up && vol > 0)
					vol--;
				env_left = env_copy[2:0] * (CPU_CLOCK_HZ / 64);
			end else begin
				env_left -= cyc;
			end
		end
	endtask

	// Advance the duty step and return the scaled level
	function automatic logic [3:0] next_level();
		longint unsigned tone, thr;
		logic [3:0] level;
		tone = 131072 / (2048 - freq);
		thr = (longint'(sample_rate) * 256) / (tone * PATTERN_STEPS);
		if (longint'(step_cnt) <= thr) begin
			step_cnt = step_cnt + 24'd256;
		end else begin
			step_idx = (step_idx + 1 >= PATTERN_STEPS) ? 3'd0 : step_idx + 3'd1;
			step_cnt = 24'(longint'(step_cnt) - thr + 256);
		end
		level = 4'(duty_tbl[duty_sel] >> (4 * step_idx));
		return 4'((vol * level) / 15);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chan_word_t w, got;
		if (!arst_n) begin
			duty_tbl[0] = 32'hF000_0000;
			duty_tbl[1] = 32'hFF00_0000;
			duty_tbl[2] = 32'hFFFF_0000;
			duty_tbl[3] = 32'h00FF_FFFF;
			sample_rate = 18'd44100;
			{len_copy, env_copy, ctl_copy, duty_sel, freq} = '0;
			{len_en, env_up, sounding, vol, step_idx, step_cnt} = '0;
			len_left = 0;
			env_left = 0;
			fail_count = 0;
			expected_words.delete();
			pending_words = 0;
		end else begin
			// Compare an output word against the oldest prediction
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[7:0], m_tdata[11:8], m_tdata[12]};
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected output word %h", m_tdata);
				end else begin
					w = expected_words.pop_front();
					if (got !== w) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected rd=%h lvl=%0d on=%b, got rd=%h lvl=%0d on=%b",
								w.rd, w.lvl, w.on, got.rd, got.lvl, got.on);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index <= CFG_DUTY3)
					duty_tbl[cfg_index[1:0]] = cfg_data;
				else if (cfg_index == CFG_RATE)
					sample_rate = cfg_data[17:0];
			end
			// Predict the word for an accepted command
			if (s_tvalid && s_tready) begin
				w = '0;
				case (cmd_t'(s_tdata[1:0]))
					CMD_READ:  w.rd = read_back(s_tdata[17:2]);
					CMD_WRITE: apply_write(s_tdata[17:2], s_tdata[25:18]);
					CMD_TICK:  apply_tick(s_tdata[35:26]);
					default:   w.lvl = next_level();
				endcase
				w.on = sounding;
				expected_words.push_back(w);
			end
			pending_words = expected_words.size();
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import sqch_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0, s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid, m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0, cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fail_count, pending_words;
	bit          quiet_phase = 0;
	bit          hold_sink = 0;

	always #1 clk = ~clk;

	square_wave_sound_channel_top DUT (.*);
	square_wave_sound_channel_checker checker_i (.*);

	// Send one command word and wait for its handshake
	task automatic send_cmd(input cmd_t c, input logic [15:0] addr, input logic [7:0] data,
			input logic [9:0] cyc);
		while (!quiet_phase && $urandom_range(99) < 13) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {4'b0, cyc, data, addr, c};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending_words != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	// Random commands, mostly at channel addresses, with reads, writes, ticks and samples
	task automatic random_cmd();
		logic [15:0] addr;
		cmd_t c;
		addr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'hFF16 + 16'($urandom_range(3));
		c = cmd_t'($urandom_range(3));
		send_cmd(c, addr, 8'($urandom), 10'($urandom));
	endtask

	// Receiver stalls, with one long hold-off while the bench keeps offering input
	always @(negedge clk) begin
		if (hold_sink)
			m_tready <= 1'b0;
		else
			m_tready <= quiet_phase || ($urandom_range(99) >= 13);
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reads of each channel address and two others, writes, trigger, ticks, samples
		send_cmd(CMD_READ, ADDR_LEN, 0, 0);
		send_cmd(CMD_SAMPLE, 0, 0, 0);
		send_cmd(CMD_READ, 16'h0000, 0, 0);
		send_cmd(CMD_READ, 16'hFFFF, 0, 0);
		send_cmd(CMD_WRITE, 16'h1234, 8'hFF, 0);
		send_cmd(CMD_WRITE, ADDR_FHI, 8'h80, 0);
		send_cmd(CMD_WRITE, ADDR_LEN, 8'hBF, 0);
		send_cmd(CMD_WRITE, ADDR_ENV, 8'hF9, 0);
		send_cmd(CMD_WRITE, ADDR_FLO, 8'hFF, 0);
		send_cmd(CMD_WRITE, ADDR_FHI, 8'hC7, 0);
		for (int i = 0; i < 4; i++) send_cmd(CMD_READ, ADDR_LEN + 16'(i), 0, 0);
		repeat (3) send_cmd(CMD_SAMPLE, 0, 0, 0);
		repeat (3) send_cmd(CMD_TICK, 0, 0, 10'h3FF);
		send_cmd(CMD_TICK, 0, 0, 0);
		send_cmd(CMD_WRITE, ADDR_ENV, 8'h0F, 0);
		send_cmd(CMD_WRITE, ADDR_FHI, 8'h80, 0);
		send_cmd(CMD_WRITE, ADDR_ENV, 8'h01, 0);
		send_cmd(CMD_TICK, 0, 0, 10'h3FF);
		drain();

		// Random phases through several table and rate settings
		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < 4; r++)
				write_cfg(3'(r), (ph == 1) ? 32'hFFFF_FFFF : (ph == 2) ? 32'h0 : $urandom);
			write_cfg(CFG_RATE, (ph == 1) ? 8000 : (ph == 2) ? 192000 :
				$urandom_range(192000, 8000));
			quiet_phase = (ph == 3);
			if (ph == 4) fork
				begin
					hold_sink = 1;
					repeat (400) @(negedge clk);
					hold_sink = 0;
				end
			join_none
			for (int k = 0; k < 220; k++) begin
				random_cmd();
				if (k == 110) drain();
			end
			drain();
		end
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

[filelist.f]
design/sqch_pkg.sv
design/sqch_div.sv
design/square_wave_sound_channel_top.sv
sim/square_wave_sound_channel_checker.sv
sim/testbench.sv
